FILE: hw/rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
`timescale 1ns / 1ps

package qrs_pkg;

    // Result status codes.
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_LINEAR = 2'd1;
    localparam logic [1:0] KIND_TWO    = 2'd2;
    localparam logic [1:0] KIND_DOUBLE = 2'd3;

    // Field widths.
    localparam int COEF_W = 16;
    localparam int ROOT_W = 40;
    localparam int DISC_W = 34;

    // Square root unit: 50-bit radicand, 25-bit root, five stages of five steps.
    localparam int SQ_IN_W     = 50;
    localparam int SQ_ROOT_W   = 25;
    localparam int SQ_REM_W    = 28;
    localparam int SQ_STEPS    = 5;
    localparam int SQ_STAGES   = 5;

    // Divider: 35-bit magnitude over 17-bit magnitude, seven stages of five steps.
    localparam int DV_NUM_W    = 35;
    localparam int DV_DEN_W    = 17;
    localparam int DV_REM_W    = 18;
    localparam int DV_STEPS    = 5;
    localparam int DV_STAGES   = 7;

    // Signed working width of the numerators before division.
    localparam int NUM_S_W     = 36;

    // Per-item context that travels beside the square root.
    typedef struct packed {
        logic [1:0]               kind;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } ctx_t;

    // Per-item side information that travels beside the first quotient.
    typedef struct packed {
        logic [1:0] kind;
        logic       neg;
    } div_tag_t;

endpackage

FILE: hw/rtl/qrs_front.sv
// Front end: coefficient products, discriminant and case selection.
`timescale 1ns / 1ps

module qrs_front
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [COEF_W-1:0] a,
    input  logic signed [COEF_W-1:0] b,
    input  logic signed [COEF_W-1:0] c,
    output logic                     out_valid,
    output ctx_t                     out_ctx,
    output logic [SQ_IN_W-1:0]       out_x
);

    logic                     v1_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg, c1_reg;
    logic signed [31:0]       bb_reg, ac_reg;
    logic signed [31:0]       bb_next, ac_next;

    logic                     v2_reg;
    ctx_t                     ctx_reg, ctx_next;
    logic [SQ_IN_W-1:0]       x_reg, x_next;
    logic signed [DISC_W-1:0] disc;

    // Both products are formed in the first stage.
    assign bb_next = b * b;
    assign ac_next = a * c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= a;
            b1_reg  <= b;
            c1_reg  <= c;
            bb_reg  <= bb_next;
            ac_reg  <= ac_next;
            ctx_reg <= ctx_next;
            x_reg   <= x_next;
        end
    end

    // Discriminant b*b - 4ac, exact in 34 bits.
    assign disc = {{(DISC_W-32){bb_reg[31]}}, bb_reg} - {ac_reg, 2'b00};

    // a == 0 or the sign of disc picks the case; only two distinct roots need a root.
    always_comb
    begin
        ctx_next.a = a1_reg;
        ctx_next.b = b1_reg;
        ctx_next.c = c1_reg;
        x_next     = '0;
        if (a1_reg == '0)
        begin
            ctx_next.kind = (b1_reg != '0) ? KIND_LINEAR : KIND_NONE;
        end
        else if (disc == '0)
        begin
            ctx_next.kind = KIND_DOUBLE;
        end
        else if (!disc[DISC_W-1])
        begin
            ctx_next.kind = KIND_TWO;
            x_next        = {1'b0, disc[DISC_W-2:0], 16'd0};
        end
        else
        begin
            ctx_next.kind = KIND_NONE;
        end
    end

    assign out_valid = v2_reg;
    assign out_ctx   = ctx_reg;
    assign out_x     = x_reg;

endmodule

FILE: hw/rtl/qrs_sqrt.sv
// Pipelined floor square root, several bit pairs per stage.
`timescale 1ns / 1ps

module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SQ_IN_W-1:0]   in_x,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic [SQ_ROOT_W-1:0] out_root,
    output logic [TAG_W-1:0]     out_tag
);

    logic                 v_s    [0:SQ_STAGES];
    logic [SQ_IN_W-1:0]   x_s    [0:SQ_STAGES];
    logic [SQ_ROOT_W-1:0] root_s [0:SQ_STAGES];
    logic [SQ_REM_W-1:0]  rem_s  [0:SQ_STAGES];
    logic [TAG_W-1:0]     tag_s  [0:SQ_STAGES];

    assign v_s[0]    = in_valid;
    assign x_s[0]    = in_x;
    assign root_s[0] = '0;
    assign rem_s[0]  = '0;
    assign tag_s[0]  = in_tag;

    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_stage
        logic                 v_reg;
        logic [SQ_IN_W-1:0]   x_reg, x_next;
        logic [SQ_ROOT_W-1:0] root_reg, root_next;
        logic [SQ_REM_W-1:0]  rem_reg, rem_next;
        logic [TAG_W-1:0]     tag_reg;
        logic [SQ_REM_W-1:0]  trial;

        // Restoring square root steps, one bit pair each.
        always_comb
        begin
            x_next    = x_s[j];
            root_next = root_s[j];
            rem_next  = rem_s[j];
            trial     = '0;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                rem_next = {rem_next[SQ_REM_W-3:0], x_next[SQ_IN_W-1 -: 2]};
                x_next   = {x_next[SQ_IN_W-3:0], 2'b00};
                trial    = {1'b0, root_next, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[SQ_ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[SQ_ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_s[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg    <= x_next;
                root_reg <= root_next;
                rem_reg  <= rem_next;
                tag_reg  <= tag_s[j];
            end
        end

        assign v_s[j+1]    = v_reg;
        assign x_s[j+1]    = x_reg;
        assign root_s[j+1] = root_reg;
        assign rem_s[j+1]  = rem_reg;
        assign tag_s[j+1]  = tag_reg;
    end

    assign out_valid = v_s[SQ_STAGES];
    assign out_root  = root_s[SQ_STAGES];
    assign out_tag   = tag_s[SQ_STAGES];

endmodule

FILE: hw/rtl/qrs_div.sv
// Pipelined unsigned restoring divider, several quotient bits per stage.
`timescale 1ns / 1ps

module qrs_div
    import qrs_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [DV_NUM_W-1:0] in_num,
    input  logic [DV_DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    output logic [DV_NUM_W-1:0] out_quo,
    output logic [TAG_W-1:0]    out_tag
);

    logic                v_s   [0:DV_STAGES];
    logic [DV_NUM_W-1:0] num_s [0:DV_STAGES];
    logic [DV_NUM_W-1:0] quo_s [0:DV_STAGES];
    logic [DV_REM_W-1:0] rem_s [0:DV_STAGES];
    logic [DV_DEN_W-1:0] den_s [0:DV_STAGES];
    logic [TAG_W-1:0]    tag_s [0:DV_STAGES];

    assign v_s[0]   = in_valid;
    assign num_s[0] = in_num;
    assign quo_s[0] = '0;
    assign rem_s[0] = '0;
    assign den_s[0] = in_den;
    assign tag_s[0] = in_tag;

    for (genvar j = 0; j < DV_STAGES; j++)
    begin : g_stage
        logic                v_reg;
        logic [DV_NUM_W-1:0] num_reg, num_next;
        logic [DV_NUM_W-1:0] quo_reg, quo_next;
        logic [DV_REM_W-1:0] rem_reg, rem_next;
        logic [DV_DEN_W-1:0] den_reg;
        logic [TAG_W-1:0]    tag_reg;

        // Shift in one dividend bit, subtract the divisor where it fits.
        always_comb
        begin
            num_next = num_s[j];
            quo_next = quo_s[j];
            rem_next = rem_s[j];
            for (int k = 0; k < DV_STEPS; k++)
            begin
                rem_next = {rem_next[DV_REM_W-2:0], num_next[DV_NUM_W-1]};
                num_next = {num_next[DV_NUM_W-2:0], 1'b0};
                if (rem_next >= {1'b0, den_s[j]})
                begin
                    rem_next = rem_next - {1'b0, den_s[j]};
                    quo_next = {quo_next[DV_NUM_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[DV_NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_s[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg <= num_next;
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                den_reg <= den_s[j];
                tag_reg <= tag_s[j];
            end
        end

        assign v_s[j+1]   = v_reg;
        assign num_s[j+1] = num_reg;
        assign quo_s[j+1] = quo_reg;
        assign rem_s[j+1] = rem_reg;
        assign den_s[j+1] = den_reg;
        assign tag_s[j+1] = tag_reg;
    end

    assign out_valid = v_s[DV_STAGES];
    assign out_quo   = quo_s[DV_STAGES];
    assign out_tag   = tag_s[DV_STAGES];

endmodule

FILE: hw/rtl/quadratic_root_solver.sv
// Top level of the pipelined fixed-point quadratic root solver.
`timescale 1ns / 1ps

// Usage: a coefficient set (coef_a, coef_b, coef_c, signed Q8.8) is taken on a
// transfer of coef_valid/coef_ready. One result (root_kind, root_one, root_two,
// roots in signed Q24.16) leaves on a transfer of root_valid/root_ready.
// Every coefficient set gives exactly one result, in order.
// From input transfer to root_valid an item passes two front stages
// (products, discriminant), five square root stages, one numerator stage,
// seven divider stages and the output register.
// Throughput is one item per cycle unless stalled; all stages advance together.
// When the receiver holds root_ready low with a result waiting, every stage
// holds and coef_ready drops; nothing is lost or repeated. An empty output
// register keeps the pipeline moving even while root_ready is low.
// Reset clears all stage valid bits, so the pipeline comes up empty and
// coef_ready is high from the first cycle after reset.

module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     coef_valid,
    output logic                     coef_ready,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                     root_valid,
    input  logic                     root_ready,
    output logic [1:0]               root_kind,
    output logic signed [ROOT_W-1:0] root_one,
    output logic signed [ROOT_W-1:0] root_two
);

    logic                 en;
    logic                 fr_valid;
    ctx_t                 fr_ctx;
    logic [SQ_IN_W-1:0]   fr_x;
    logic                 sq_valid;
    logic [SQ_ROOT_W-1:0] sq_root;
    ctx_t                 sq_ctx;

    logic                     nm_v_reg;
    logic [DV_NUM_W-1:0]      n1_reg, n1_next, n2_reg, n2_next;
    logic [DV_DEN_W-1:0]      den_reg, den_next;
    div_tag_t                 t1_reg, t1_next;
    logic                     neg2_reg, neg2_next;

    logic signed [NUM_S_W-1:0]  bx, cx, nb, sx, s1, s2;
    logic signed [DV_DEN_W-1:0] den_s;

    logic                 d1_valid, d2_valid;
    logic [DV_NUM_W-1:0]  q1, q2;
    div_tag_t             d1_tag;
    logic                 d2_neg;

    logic                     out_v_reg;
    logic [1:0]               kind_reg;
    logic signed [ROOT_W-1:0] r1_reg, r1_next, r2_reg, r2_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign en         = !out_v_reg || root_ready;
    assign coef_ready = en;

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coef_valid),
        .a         (coef_a),
        .b         (coef_b),
        .c         (coef_c),
        .out_valid (fr_valid),
        .out_ctx   (fr_ctx),
        .out_x     (fr_x)
    );

    qrs_sqrt #(.TAG_W($bits(ctx_t))) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_x      (fr_x),
        .in_tag    (fr_ctx),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_ctx)
    );

    // Numerators and divisor per case, then split into sign and magnitude.
    assign bx = NUM_S_W'(sq_ctx.b);
    assign cx = NUM_S_W'(sq_ctx.c);
    assign nb = -(bx <<< 8);
    assign sx = NUM_S_W'(sq_root);

    always_comb
    begin
        s1    = '0;
        s2    = '0;
        den_s = DV_DEN_W'(1);
        unique case (sq_ctx.kind)
            KIND_LINEAR:
            begin
                s1    = -(cx <<< 16);
                den_s = DV_DEN_W'(sq_ctx.b);
            end
            KIND_TWO:
            begin
                s1    = (nb + sx) <<< 8;
                s2    = (nb - sx) <<< 8;
                den_s = {sq_ctx.a, 1'b0};
            end
            KIND_DOUBLE:
            begin
                s1    = -(bx <<< 16);
                den_s = {sq_ctx.a, 1'b0};
            end
            default:
            begin
                s1    = '0;
            end
        endcase
        n1_next      = s1[NUM_S_W-1] ? DV_NUM_W'(-s1) : DV_NUM_W'(s1);
        n2_next      = s2[NUM_S_W-1] ? DV_NUM_W'(-s2) : DV_NUM_W'(s2);
        den_next     = den_s[DV_DEN_W-1] ? DV_DEN_W'(-den_s) : DV_DEN_W'(den_s);
        t1_next.kind = sq_ctx.kind;
        t1_next.neg  = s1[NUM_S_W-1] ^ den_s[DV_DEN_W-1];
        neg2_next    = s2[NUM_S_W-1] ^ den_s[DV_DEN_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            nm_v_reg  <= sq_valid;
            out_v_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            den_reg  <= den_next;
            t1_reg   <= t1_next;
            neg2_reg <= neg2_next;
            kind_reg <= d1_tag.kind;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
        end
    end

    qrs_div #(.TAG_W($bits(div_tag_t))) u_div_one (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_v_reg),
        .in_num    (n1_reg),
        .in_den    (den_reg),
        .in_tag    (t1_reg),
        .out_valid (d1_valid),
        .out_quo   (q1),
        .out_tag   (d1_tag)
    );

    qrs_div #(.TAG_W(1)) u_div_two (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_v_reg),
        .in_num    (n2_reg),
        .in_den    (den_reg),
        .in_tag    (neg2_reg),
        .out_valid (d2_valid),
        .out_quo   (q2),
        .out_tag   (d2_neg)
    );

    // Restore the quotient signs; division truncates toward zero.
    assign r1_next = d1_tag.neg ? -ROOT_W'(q1) : ROOT_W'(q1);
    assign r2_next = (d2_neg && d2_valid) ? -ROOT_W'(q2) : ROOT_W'(q2);

    assign root_valid = out_v_reg;
    assign root_kind  = kind_reg;
    assign root_one   = r1_reg;
    assign root_two   = r2_reg;

endmodule
